FILE: rtl/software_timer_bank_top_assert.svh
// assertion macros shared by the timer bank modules
`ifndef SOFTWARE_TIMER_BANK_TOP_ASSERT_SVH
`define SOFTWARE_TIMER_BANK_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define STB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define STB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/stb_pkg.sv
`timescale 1ns / 1ps

package stb_pkg;

  localparam int NUM_TIMERS = 4;
  localparam int SLOTS      = 4;
  localparam int SLOT_W     = 2;
  localparam int TIME_W     = 32;
  localparam int ELAPSED_W  = 16;
  localparam int CFG_IDX_W  = 3;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_TIMERS - 1);

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERIODIC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RELOAD_3 = 3'd5;

  typedef enum logic [1:0] {
    ST_DISABLED = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_EXPIRED  = 2'd2
  } timer_status_t;

  typedef struct packed {
    logic              add_total;
    logic              tick_slot;
    logic              fire_slot;
    logic              load_out;
    logic              out_fired;
    logic              out_last;
    logic [SLOT_W-1:0] slot;
  } stb_cmd_t;

  typedef struct packed {
    logic [SLOTS-1:0] fire_vec;
    logic             out_free;
  } stb_stat_t;

endpackage

FILE: rtl/software_timer_bank_top.sv
`timescale 1ns / 1ps
// bank of four millisecond timers with an enable mask and periodic/one-shot reload
// input channel item_valid/item_stall carries cmd (0 tick, 1 dispatch) and elapsed
// output channel result_valid/result_stall carries fired_valid, fired_index,
//   ms_total and last; last marks the final word caused by one input word
// a tick adds elapsed to ms_total and counts down each enabled running timer,
//   visiting one timer slot per cycle through the shared subtract/compare
// tick: the slot walk visits all four slots, then S_TICK_OUT loads the output word
// dispatch: one slot per cycle unless the output stalls, one word per expired
//   enabled timer in index order, or a single word, fired_valid low, if none expired
// item_stall is high while a word is in work; the next word is taken as soon
//   as the last result sits in the output register, even if it is still stalled
// a stalled output register holds its word and pauses the dispatch slot walk
// config writes (cfg_we, cfg_index, cfg_data) act at once and belong to idle time
// reset: all timers running with countdown zero, the running total zero, enable_mask all
//   ones, periodic_mask and reloads zero, output register empty
module software_timer_bank_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          cmd,
  input  logic [stb_pkg::ELAPSED_W-1:0] elapsed,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          fired_valid,
  output logic [stb_pkg::SLOT_W-1:0]    fired_index,
  output logic [stb_pkg::TIME_W-1:0]    ms_total,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stb_pkg::TIME_W-1:0]    cfg_data
);
  import stb_pkg::*;

  stb_cmd_t  ctl;
  stb_stat_t stat;

  stb_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .stat       (stat),
    .ctl        (ctl)
  );

  stb_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .elapsed      (elapsed),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ctl          (ctl),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .fired_valid  (fired_valid),
    .fired_index  (fired_index),
    .ms_total     (ms_total),
    .last         (last)
  );

endmodule

FILE: rtl/stb_dp.sv
`timescale 1ns / 1ps

module stb_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [stb_pkg::ELAPSED_W-1:0] elapsed,
  input  logic                          cfg_we,
  input  logic [stb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stb_pkg::TIME_W-1:0]    cfg_data,
  input  stb_pkg::stb_cmd_t             ctl,
  output stb_pkg::stb_stat_t            stat,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          fired_valid,
  output logic [stb_pkg::SLOT_W-1:0]    fired_index,
  output logic [stb_pkg::TIME_W-1:0]    ms_total,
  output logic                          last
);
  import stb_pkg::*;

  `include "software_timer_bank_top_assert.svh"

  logic [SLOTS-1:0]     enable_mask;
  logic [SLOTS-1:0]     periodic_mask;
  logic [TIME_W-1:0]    reload [SLOTS];
  logic [TIME_W-1:0]    countdown [SLOTS];
  timer_status_t        status [SLOTS];
  logic [TIME_W-1:0]    total;
  logic [ELAPSED_W-1:0] el;
  logic [TIME_W-1:0]    el_wide;
  logic [TIME_W-1:0]    cur_count;

  assign el_wide   = {{(TIME_W-ELAPSED_W){1'b0}}, el};
  assign cur_count = countdown[ctl.slot];

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      stat.fire_vec[i] = (i < NUM_TIMERS) && enable_mask[i] && (status[i] == ST_EXPIRED);
    end
    stat.out_free = !result_valid || !result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_mask   <= '1;
      periodic_mask <= '0;
      total         <= '0;
      result_valid  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        reload[i]    <= '0;
        countdown[i] <= '0;
        status[i]    <= ST_RUNNING;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:   enable_mask   <= cfg_data[SLOTS-1:0];
          REG_PERIODIC: periodic_mask <= cfg_data[SLOTS-1:0];
          REG_RELOAD_0: reload[0]     <= cfg_data;
          REG_RELOAD_1: reload[1]     <= cfg_data;
          REG_RELOAD_2: reload[2]     <= cfg_data;
          REG_RELOAD_3: reload[3]     <= cfg_data;
          default: ;
        endcase
      end
      if (ctl.add_total) begin
        total <= total + {{(TIME_W-ELAPSED_W){1'b0}}, elapsed};
      end
      if (ctl.tick_slot && enable_mask[ctl.slot] && (status[ctl.slot] == ST_RUNNING)) begin
        if (cur_count > el_wide) begin
          countdown[ctl.slot] <= cur_count - el_wide;
        end else begin
          countdown[ctl.slot] <= '0;
          status[ctl.slot]    <= ST_EXPIRED;
        end
      end
      if (ctl.fire_slot) begin
        if (periodic_mask[ctl.slot]) begin
          countdown[ctl.slot] <= reload[ctl.slot];
          status[ctl.slot]    <= ST_RUNNING;
        end else begin
          status[ctl.slot] <= ST_DISABLED;
        end
      end
      if (ctl.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.add_total) begin
      el <= elapsed;
    end
    if (ctl.load_out) begin
      fired_valid <= ctl.out_fired;
      fired_index <= ctl.out_fired ? ctl.slot : '0;
      ms_total    <= total;
      last        <= ctl.out_last;
    end
  end

  `STB_ASSERT_NEXT(a_fire_clears, ctl.fire_slot, !stat.fire_vec[$past(ctl.slot)], "fired timer still expired")
  `STB_ASSERT_NEXT(a_load_shows, ctl.load_out, result_valid, "loaded word not presented")
  `STB_ASSERT_NEXT(a_total_adds, ctl.add_total, total == $past(total) + {{(TIME_W-ELAPSED_W){1'b0}}, $past(elapsed)}, "total not advanced by elapsed")

endmodule

FILE: rtl/stb_ctrl.sv
`timescale 1ns / 1ps

module stb_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic                cmd,
  input  stb_pkg::stb_stat_t  stat,
  output stb_pkg::stb_cmd_t   ctl
);
  import stb_pkg::*;

  `include "software_timer_bank_top_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK,
    S_TICK_OUT,
    S_DISP,
    S_NONE_OUT
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] slot;
  logic              accept;
  logic [SLOTS-1:0]  above;
  logic              later;

  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_comb begin
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = (j > int'(slot));
    end
    later = |(stat.fire_vec & above);
  end

  always_comb begin
    ctl           = '0;
    ctl.slot      = slot;
    case (state)
      S_IDLE: begin
        ctl.add_total = accept && (cmd == CMD_TICK);
      end
      S_TICK: begin
        ctl.tick_slot = 1'b1;
      end
      S_TICK_OUT, S_NONE_OUT: begin
        ctl.load_out = stat.out_free;
        ctl.out_last = 1'b1;
      end
      S_DISP: begin
        if (stat.fire_vec[slot] && stat.out_free) begin
          ctl.fire_slot = 1'b1;
          ctl.load_out  = 1'b1;
          ctl.out_fired = 1'b1;
          ctl.out_last  = !later;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            slot <= '0;
            if (cmd == CMD_TICK) begin
              state <= S_TICK;
            end else if (stat.fire_vec == '0) begin
              state <= S_NONE_OUT;
            end else begin
              state <= S_DISP;
            end
          end
        end
        S_TICK: begin
          if (slot == LAST_SLOT) begin
            state <= S_TICK_OUT;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        S_TICK_OUT, S_NONE_OUT: begin
          if (stat.out_free) begin
            state <= S_IDLE;
          end
        end
        S_DISP: begin
          if (stat.fire_vec[slot]) begin
            if (stat.out_free) begin
              if (!later || slot == LAST_SLOT) begin
                state <= S_IDLE;
              end else begin
                slot <= slot + 1'b1;
              end
            end
          end else if (slot == LAST_SLOT) begin
            state <= S_IDLE;
          end else begin
            slot <= slot + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `STB_ASSERT_NOW(a_load_free, ctl.load_out, stat.out_free, "output loaded while occupied")
  `STB_ASSERT_NOW(a_fire_ready, ctl.fire_slot, stat.fire_vec[ctl.slot], "fired a timer that had not expired")
  `STB_ASSERT_NOW(a_fire_emits, ctl.fire_slot, ctl.load_out && ctl.out_fired, "fire without an emitted word")

endmodule
